// ----- sv/ccpp_pkg.sv -----
// Shared constants, status codes and types for the checksummed command packet parser.
// No dependencies; every other file depends on this package.
package ccpp_pkg;

    localparam int SETTINGS_ENTRIES = 16;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 4;
    localparam int INDEX_W  = 4;

    localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(264);
    localparam logic [POS_W-1:0] HEADER_BYTES  = POS_W'(8);
    localparam logic [POS_W-1:0] MIN_PACKET    = POS_W'(9);
    localparam logic [POS_W-1:0] ENTRIES_LIMIT = POS_W'(SETTINGS_ENTRIES);

    localparam logic [BYTE_W-1:0] MAGIC0_BYTE  = 8'hA5;
    localparam logic [BYTE_W-1:0] MAGIC1_BYTE  = 8'h5A;
    localparam logic [BYTE_W-1:0] VERSION_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] KIND_HELLO   = 8'h01;
    localparam logic [BYTE_W-1:0] KIND_AUTH    = 8'h02;
    localparam logic [BYTE_W-1:0] KIND_WRITE   = 8'h03;
    localparam logic [BYTE_W-1:0] KEY_BYTE0    = 8'h42;
    localparam logic [BYTE_W-1:0] KEY_BYTE1    = 8'h13;
    localparam logic [BYTE_W-1:0] KEY_BYTE2    = 8'h37;
    localparam logic [BYTE_W-1:0] KEY_MASK     = 8'h5A;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_MAGIC0  = 2'd1;
    localparam logic [1:0] FAULT_MAGIC1  = 2'd2;
    localparam logic [1:0] FAULT_VERSION = 2'd3;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK       = 4'd0;
    localparam status_t ST_SHORT    = 4'd1;
    localparam status_t ST_MAGIC0   = 4'd2;
    localparam status_t ST_MAGIC1   = 4'd3;
    localparam status_t ST_VERSION  = 4'd4;
    localparam status_t ST_LENGTH   = 4'd5;
    localparam status_t ST_CHECKSUM = 4'd6;
    localparam status_t ST_UNKNOWN  = 4'd7;
    localparam status_t ST_PAYLOAD  = 4'd8;
    localparam status_t ST_AUTH     = 4'd9;
    localparam status_t ST_RANGE    = 4'd10;

    typedef logic [3:0][BYTE_W-1:0] head_t;

    // Packet fields as they stand once the current byte is folded in.
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [1:0]        fault;
        logic [BYTE_W-1:0] kind;
        logic              hello;
        logic [BYTE_W-1:0] session;
        logic [BYTE_W-1:0] length;
        logic [1:0]        sums_ok;
        head_t             head;
    } pkt_view_t;

endpackage

// ----- sv/ccpp_byte_if.sv -----
// Byte request channel: one packet byte plus its end-of-packet flag.
// Depends on ccpp_pkg for widths.
interface ccpp_byte_if;
    logic                           valid;
    logic                           ready;
    logic [ccpp_pkg::BYTE_W-1:0]    data_byte;
    logic                           last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- sv/ccpp_result_if.sv -----
// Result request channel: one status report per packet.
// Depends on ccpp_pkg for widths and the status type.
interface ccpp_result_if;
    logic                           valid;
    logic                           ready;
    ccpp_pkg::status_t              status;
    logic                           is_authenticated;
    logic [ccpp_pkg::BYTE_W-1:0]    current_session;
    logic                           entry_written;
    logic [ccpp_pkg::INDEX_W-1:0]   entry_index;
    logic [ccpp_pkg::BYTE_W-1:0]    entry_value;

    modport source (output valid, output status, output is_authenticated,
                    output current_session, output entry_written,
                    output entry_index, output entry_value, input ready);
    modport sink   (input valid, input status, input is_authenticated,
                    input current_session, input entry_written,
                    input entry_index, input entry_value, output ready);
endinterface

// ----- sv/ccpp_parse.sv -----
// Per-packet byte tracker: position, header fields, running sums, payload head.
// Depends on ccpp_pkg.
module ccpp_parse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [ccpp_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         last_byte,
    output ccpp_pkg::pkt_view_t          view
);
    import ccpp_pkg::*;

    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [1:0]        fault_reg,   fault_next;
    logic [BYTE_W-1:0] kind_reg,    kind_next;
    logic              hello_reg,   hello_next;
    logic [BYTE_W-1:0] session_reg, session_next;
    logic [BYTE_W-1:0] length_reg,  length_next;
    logic [BYTE_W-1:0] sum_reg,     sum_next;
    logic [1:0]        match_reg,   match_next;
    head_t             head_reg,    head_next;
    logic [POS_W-1:0]  sum_pos;

    always_comb
    begin
        sum_pos      = HEADER_BYTES + {1'b0, length_reg};
        pos_next     = (pos_reg < POS_LIMIT) ? pos_reg + POS_W'(1) : pos_reg;
        fault_next   = fault_reg;
        kind_next    = kind_reg;
        hello_next   = hello_reg;
        session_next = session_reg;
        length_next  = length_reg;
        sum_next     = sum_reg;
        match_next   = match_reg;
        head_next    = head_reg;

        // Keep only the first header fault.
        if (fault_reg == FAULT_NONE)
        begin
            if (pos_reg == POS_W'(0) && data_byte != MAGIC0_BYTE)
                fault_next = FAULT_MAGIC0;
            else if (pos_reg == POS_W'(1) && data_byte != MAGIC1_BYTE)
                fault_next = FAULT_MAGIC1;
            else if (pos_reg == POS_W'(2) && data_byte != VERSION_BYTE)
                fault_next = FAULT_VERSION;
        end

        if (pos_reg == POS_W'(3)) kind_next    = data_byte;
        if (pos_reg == POS_W'(4)) hello_next   = data_byte[0];
        if (pos_reg == POS_W'(5)) session_next = data_byte;
        if (pos_reg == POS_W'(6)) length_next  = data_byte;

        if (pos_reg < POS_W'(7))
            sum_next = sum_reg + data_byte;
        else if (pos_reg == POS_W'(7))
        begin
            if (data_byte == sum_reg) match_next[0] = 1'b1;
            sum_next = '0;
        end
        else if (pos_reg < sum_pos)
            sum_next = sum_reg + data_byte;
        else if (pos_reg == sum_pos)
        begin
            if (data_byte == sum_reg) match_next[1] = 1'b1;
        end

        if (pos_reg >= HEADER_BYTES && pos_reg < HEADER_BYTES + POS_W'(4))
            head_next[pos_reg[1:0]] = data_byte;
    end

    always_comb
    begin
        view.position = pos_next;
        view.fault    = fault_next;
        view.kind     = kind_next;
        view.hello    = hello_next;
        view.session  = session_next;
        view.length   = length_next;
        view.sums_ok  = match_next;
        view.head     = head_next;
    end

    // Clear all packet state but the payload head once the final byte is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            fault_reg   <= FAULT_NONE;
            kind_reg    <= '0;
            hello_reg   <= 1'b0;
            session_reg <= '0;
            length_reg  <= '0;
            sum_reg     <= '0;
            match_reg   <= '0;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg     <= '0;
                fault_reg   <= FAULT_NONE;
                kind_reg    <= '0;
                hello_reg   <= 1'b0;
                session_reg <= '0;
                length_reg  <= '0;
                sum_reg     <= '0;
                match_reg   <= '0;
            end
            else
            begin
                pos_reg     <= pos_next;
                fault_reg   <= fault_next;
                kind_reg    <= kind_next;
                hello_reg   <= hello_next;
                session_reg <= session_next;
                length_reg  <= length_next;
                sum_reg     <= sum_next;
                match_reg   <= match_next;
            end
        end
    end

    // Payload head is only read after this packet has written it.
    always_ff @(posedge clk)
    begin
        if (take) head_reg <= head_next;
    end

endmodule

// ----- sv/checksummed_command_packet_parser_unit.sv -----
// Top level of the checksummed command packet parser.
// Depends on ccpp_pkg, ccpp_byte_if, ccpp_result_if and ccpp_parse.
//
// Packet bytes arrive on the byte channel, one request per byte, with
// last_byte set on the final byte. The block takes one byte every cycle
// unless a final byte is stalled waiting for the result register: each
// byte is registered, folded into the packet tracker and, on the final
// byte, judged in the same cycle into a result register. A result is reported
// only for the final byte of a packet. The status is chosen in priority
// order short, magic0, magic1, version, length, checksum (header or payload
// sum), then by type (HELLO, AUTH, WRITE_CONFIG, otherwise unknown). The session
// number and the authenticated flag persist across packets; a successful
// WRITE_CONFIG reports the written settings entry (index and value) on the
// result so the entry can be held by its consumer, and index/value read zero
// otherwise. While a result waits, bytes of the next packet keep flowing;
// only a final byte waits for the result register to free up.
module checksummed_command_packet_parser_unit (
    input  logic          clk,
    input  logic          rst_n,
    ccpp_byte_if.sink     bytes,
    ccpp_result_if.source results
);
    import ccpp_pkg::*;

    // Input register
    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_last_reg;
    logic              s1_advance;

    // Persistent session state
    logic              auth_reg,    auth_next;
    logic [BYTE_W-1:0] session_reg, session_next;

    // Result register
    logic               out_valid_reg;
    status_t            status_reg,   status_next;
    logic               written_reg,  written_next;
    logic [INDEX_W-1:0] index_reg,    index_next;
    logic [BYTE_W-1:0]  value_reg,    value_next;

    pkt_view_t view;
    logic      report;
    logic      key_ok;

    // A non-final byte never needs the result register; a final one does.
    assign s1_advance   = s1_valid_reg &&
                          (!s1_last_reg || !out_valid_reg || results.ready);
    assign bytes.ready  = !s1_valid_reg || s1_advance;
    assign report       = s1_advance && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (bytes.ready)
            s1_valid_reg <= bytes.valid;
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_last_reg <= bytes.last_byte;
        end
    end

    ccpp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (s1_advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .view      (view)
    );

    assign key_ok = view.head[0] == KEY_BYTE0 && view.head[1] == KEY_BYTE1 &&
                    view.head[2] == KEY_BYTE2 &&
                    view.head[3] == (view.session ^ KEY_MASK);

    // Judge the packet in priority order.
    always_comb
    begin
        status_next  = ST_OK;
        auth_next    = auth_reg;
        session_next = session_reg;
        written_next = 1'b0;
        index_next   = '0;
        value_next   = '0;

        if (view.position < MIN_PACKET)
            status_next = ST_SHORT;
        else if (view.fault != FAULT_NONE)
        begin
            unique case (view.fault)
                FAULT_MAGIC0: status_next = ST_MAGIC0;
                FAULT_MAGIC1: status_next = ST_MAGIC1;
                default:      status_next = ST_VERSION;
            endcase
        end
        else if (HEADER_BYTES + {1'b0, view.length} >= view.position)
            status_next = ST_LENGTH;
        else if (view.sums_ok != 2'b11)
            status_next = ST_CHECKSUM;
        else if (view.kind == KIND_HELLO)
        begin
            if (view.length > 8'd1)
                status_next = ST_PAYLOAD;
            else if (view.hello)
                session_next = view.session;
        end
        else if (view.kind == KIND_AUTH)
        begin
            if (view.length < 8'd4)
                status_next = ST_PAYLOAD;
            else if (key_ok)
            begin
                auth_next    = 1'b1;
                session_next = view.session;
            end
            else
            begin
                auth_next   = 1'b0;
                status_next = ST_AUTH;
            end
        end
        else if (view.kind == KIND_WRITE)
        begin
            if (view.length < 8'd2)
                status_next = ST_PAYLOAD;
            else if (!auth_reg)
                status_next = ST_AUTH;
            else if ({1'b0, view.head[0]} < ENTRIES_LIMIT)
            begin
                written_next = 1'b1;
                index_next   = view.head[0][INDEX_W-1:0];
                value_next   = view.head[1];
            end
            else
                status_next = ST_RANGE;
        end
        else
            status_next = ST_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auth_reg      <= 1'b0;
            session_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (report)
            begin
                auth_reg    <= auth_next;
                session_reg <= session_next;
            end
            // Hold the result until taken; load a new one when judged.
            if (report)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (report)
        begin
            status_reg  <= status_next;
            written_reg <= written_next;
            index_reg   <= index_next;
            value_reg   <= value_next;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.status           = status_reg;
    assign results.is_authenticated = auth_reg;
    assign results.current_session  = session_reg;
    assign results.entry_written    = written_reg;
    assign results.entry_index      = index_reg;
    assign results.entry_value      = value_reg;

    // A written entry only comes from an authenticated, clean packet.
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && written_reg |-> status_reg == ST_OK && auth_reg)
        else $error("entry written without ok status or authentication");

    // No entry reported means index and value read zero.
    a_idle_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !written_reg |-> index_reg == '0 && value_reg == '0)
        else $error("entry fields set without a write");

    // A result appears only after a final byte was judged.
    a_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !report |=> !out_valid_reg)
        else $error("result raised without a final byte");

    // Session state moves only on a judged final byte.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !report |=> $stable(auth_reg) && $stable(session_reg))
        else $error("session state changed between packets");

endmodule
